FILE: hw/rtl/sha1_pkg.sv
// Shared types and constants for the SHA-1 byte stream hasher.
// No dependencies; imported by sha1_datapath, sha1_ctrl and the top level.
`timescale 1ns / 1ps
package sha1_pkg;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] IV_E = 32'hc3d2e1f0;

  localparam logic [2:0] REG_INIT_A = 3'd0;
  localparam logic [2:0] REG_INIT_B = 3'd1;
  localparam logic [2:0] REG_INIT_C = 3'd2;
  localparam logic [2:0] REG_INIT_D = 3'd3;
  localparam logic [2:0] REG_INIT_E = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_iv;     // copy starting vector into hash words
    logic       put_byte;    // write the data byte or pad_val at byte_pos in the schedule
    logic [5:0] byte_pos;
    logic [7:0] pad_val;
    logic       put_len;     // write bit length into words 14 and 15
    logic       cnt_inc;
    logic       cnt_clr;
    logic       start_blk;   // load working words from hash words
    logic       round_en;
    logic [6:0] round;
    logic       fold;        // add working words into hash words
  } sha1_cmd_t;

  typedef struct packed {
    logic [5:0] cnt_low;
  } sha1_stat_t;

endpackage

FILE: hw/rtl/sha1_datapath.sv
// SHA-1 datapath: hash words, working words, rolling schedule, byte count.
// Depends on sha1_pkg; driven by sha1_ctrl.
`timescale 1ns / 1ps
module sha1_datapath import sha1_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  sha1_cmd_t        cmd,
  input  logic [7:0]       data_byte,
  input  logic             use_data,
  input  logic [159:0]     init_words,
  input  logic [2:0]       out_sel,
  output logic [31:0]      digest_word,
  output sha1_stat_t       stat
);

  logic [31:0] hash_r [5];
  logic [31:0] v_r [5];
  logic [31:0] w_r [16];
  logic [60:0] cnt_r;

  logic [3:0]  widx;
  logic [31:0] wsched;
  logic [31:0] wcur;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;
  logic [7:0]  bval;
  logic [63:0] bits;

  assign stat.cnt_low = cnt_r[5:0];
  assign widx   = cmd.round[3:0];
  assign wsched = w_r[widx + 4'd13] ^ w_r[widx + 4'd8] ^ w_r[widx + 4'd2] ^ w_r[widx];
  assign wcur   = (cmd.round < 7'd16) ? w_r[widx] : {wsched[30:0], wsched[31]};
  assign bval   = use_data ? data_byte : cmd.pad_val;
  assign bits   = {cnt_r, 3'b000};

  always_comb begin
    if (cmd.round < 7'd20) begin
      f = (v_r[1] & v_r[2]) ^ (~v_r[1] & v_r[3]);
      k = K0;
    end else if (cmd.round < 7'd40) begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = K1;
    end else if (cmd.round < 7'd60) begin
      f = (v_r[1] & v_r[2]) ^ (v_r[1] & v_r[3]) ^ (v_r[2] & v_r[3]);
      k = K2;
    end else begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = K3;
    end
  end

  assign tmp = {v_r[0][26:0], v_r[0][31:27]} + f + k + v_r[4] + wcur;

  always_comb begin
    case (out_sel)
      3'd0:    digest_word = hash_r[0];
      3'd1:    digest_word = hash_r[1];
      3'd2:    digest_word = hash_r[2];
      3'd3:    digest_word = hash_r[3];
      default: digest_word = hash_r[4];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 61'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r[0] <= IV_A;
      hash_r[1] <= IV_B;
      hash_r[2] <= IV_C;
      hash_r[3] <= IV_D;
      hash_r[4] <= IV_E;
    end else if (cmd.load_iv) begin
      for (int i = 0; i < 5; i++) hash_r[i] <= init_words[32*i +: 32];
    end else if (cmd.fold) begin
      for (int i = 0; i < 5; i++) hash_r[i] <= hash_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_blk) begin
      for (int i = 0; i < 5; i++) v_r[i] <= hash_r[i];
    end else if (cmd.round_en) begin
      v_r[4] <= v_r[3];
      v_r[3] <= v_r[2];
      v_r[2] <= {v_r[1][1:0], v_r[1][31:2]};
      v_r[1] <= v_r[0];
      v_r[0] <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      case (cmd.byte_pos[1:0])
        2'd0:    w_r[cmd.byte_pos[5:2]] <= {bval, 24'd0};
        2'd1:    w_r[cmd.byte_pos[5:2]][23:16] <= bval;
        2'd2:    w_r[cmd.byte_pos[5:2]][15:8] <= bval;
        default: w_r[cmd.byte_pos[5:2]][7:0] <= bval;
      endcase
    end else if (cmd.put_len) begin
      w_r[14] <= bits[63:32];
      w_r[15] <= bits[31:0];
    end else if (cmd.round_en && cmd.round >= 7'd16) begin
      w_r[widx] <= wcur;
    end
  end

endmodule

FILE: hw/rtl/sha1_ctrl.sv
// SHA-1 sequencer: byte intake, padding, 80 rounds per block, digest output.
// Depends on sha1_pkg; commands sha1_datapath.
`timescale 1ns / 1ps
module sha1_ctrl import sha1_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       byte_present,
  input  logic       end_of_message,
  output logic       use_data,
  input  sha1_stat_t stat,
  output sha1_cmd_t  cmd,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [2:0] out_sel
);

  state_t      state_r, state_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        fin_r, fin_nxt;    // end of message taken; with pos_r at 56 the block running is the last one
  logic        started_r, started_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic        acc;
  logic [5:0]  pos_next;

  assign out_sel = sel_r;
  assign acc = in_tvalid && in_tready;
  assign pos_next = stat.cnt_low + 6'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      round_r   <= '0;
      // Outside padding the position rests on the length field, so a zero
      // after a fold only ever marks the second pad block.
      pos_r     <= 6'd56;
      fin_r     <= 1'b0;
      started_r <= 1'b0;
      sel_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      round_r   <= round_nxt;
      pos_r     <= pos_nxt;
      fin_r     <= fin_nxt;
      started_r <= started_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    round_nxt   = round_r;
    pos_nxt     = pos_r;
    fin_nxt     = fin_r;
    started_nxt = started_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.round   = round_r;
    use_data    = 1'b0;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (acc && (byte_present || end_of_message)) begin
          cmd.load_iv = !started_r;
          started_nxt = 1'b1;
          if (byte_present) begin
            use_data     = 1'b1;
            cmd.put_byte = 1'b1;
            cmd.byte_pos = stat.cnt_low;
            cmd.cnt_inc  = 1'b1;
          end
          if (end_of_message) begin
            // Pad from the position after any byte taken in this beat.
            pos_nxt   = byte_present ? pos_next : stat.cnt_low;
            fin_nxt   = 1'b0;
            state_nxt = ST_PAD;
          end else if (pos_next == 6'd0) begin
            fin_nxt   = 1'b0;
            round_nxt = '0;
            state_nxt = ST_ROUND;
          end
          // No pending message byte beat leaves pad flag clear.
          if (end_of_message && byte_present && pos_next == 6'd0) begin
            // Full block first; padding begins at byte zero afterwards.
            pos_nxt   = '0;
            round_nxt = '0;
            state_nxt = ST_ROUND;
            fin_nxt   = 1'b1;
          end
        end
        if (state_nxt == ST_ROUND) cmd.start_blk = 1'b1;
      end
      ST_PAD: begin
        // One byte a cycle: 0x80 at the first position, zeros after.
        cmd.put_byte = 1'b1;
        cmd.byte_pos = pos_r;
        cmd.pad_val  = (pos_r == stat.cnt_low) ? PAD_BYTE : 8'd0;
        pos_nxt      = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          round_nxt     = '0;
          cmd.start_blk = 1'b1;
          fin_nxt       = 1'b0;
          state_nxt     = ST_ROUND;
        end else if (pos_r == 6'd55) begin
          cmd.put_byte  = 1'b1;
          round_nxt     = '0;
          fin_nxt       = 1'b1;
          state_nxt     = ST_FOLD;
          round_nxt     = 7'd127;
        end
      end
      ST_ROUND: begin
        if (round_r == 7'd127) begin
          // Length words land after the last pad byte, then rounds start.
          cmd.put_len   = 1'b1;
          cmd.start_blk = 1'b1;
          round_nxt     = '0;
        end else begin
          cmd.round_en = 1'b1;
          round_nxt    = round_r + 7'd1;
          if (round_r == 7'd79) state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (round_r == 7'd127) begin
          state_nxt = ST_ROUND;
        end else begin
          cmd.fold = 1'b1;
          if (fin_r && pos_r == 6'd56) begin
            state_nxt = ST_OUT;
            sel_nxt   = '0;
          end else if (fin_r) begin
            // Full message block done with end pending: pad a fresh block.
            pos_nxt   = '0;
            fin_nxt   = 1'b0;
            state_nxt = ST_PAD;
          end else if (pos_r == 6'd0 && !started_r) begin
            state_nxt = ST_IDLE;
          end else if (pos_r == 6'd0) begin
            // Overflow pad block done: zero-fill the next one.
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          sel_nxt = sel_r + 3'd1;
          if (sel_r == 3'd4) begin
            cmd.load_iv = 1'b1;
            cmd.cnt_clr = 1'b1;
            started_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/sha1_byte_stream_hasher_core.sv
// Top level of the SHA-1 byte stream hasher: APB registers, controller, datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_datapath.
`timescale 1ns / 1ps
// One byte is taken per beat; a beat that completes a 64-byte block is
// followed by the 80 rounds and the fold, with no input taken. An end beat
// pads one byte per cycle up to the length field, runs one or two blocks,
// then presents the five digest words on five output beats. The round
// engine, one round per cycle, sets the byte rate.
module sha1_byte_stream_hasher_core import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_position
  output logic        out_tlast,  // last_word
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] init_r [5];
  logic [159:0] init_words;
  sha1_cmd_t   cmd;
  sha1_stat_t  stat;
  logic        use_data;
  logic [2:0]  sel;
  logic [31:0] digest;
  logic [2:0]  ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r[0] <= IV_A;
      init_r[1] <= IV_B;
      init_r[2] <= IV_C;
      init_r[3] <= IV_D;
      init_r[4] <= IV_E;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        REG_INIT_A: init_r[0] <= cfg_pwdata;
        REG_INIT_B: init_r[1] <= cfg_pwdata;
        REG_INIT_C: init_r[2] <= cfg_pwdata;
        REG_INIT_D: init_r[3] <= cfg_pwdata;
        REG_INIT_E: init_r[4] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_INIT_A: cfg_prdata = init_r[0];
      REG_INIT_B: cfg_prdata = init_r[1];
      REG_INIT_C: cfg_prdata = init_r[2];
      REG_INIT_D: cfg_prdata = init_r[3];
      REG_INIT_E: cfg_prdata = init_r[4];
      default:    cfg_prdata = '0;
    endcase
  end

  assign init_words = {init_r[4], init_r[3], init_r[2], init_r[1], init_r[0]};

  sha1_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .byte_present(in_tuser), .end_of_message(in_tlast),
    .use_data, .stat, .cmd, .out_tvalid, .out_tready, .out_sel(sel)
  );

  sha1_datapath u_dp (
    .clk, .rst_n, .cmd, .data_byte(in_tdata), .use_data, .init_words,
    .out_sel(sel), .digest_word(digest), .stat
  );

  assign out_tdata = {5'd0, sel, digest};
  assign out_tlast = (sel == 3'd4);

endmodule

FILE: hw/rtl/sha1_checker.sv
// Port-level checks for the SHA-1 hasher, bound to the top level.
// Depends on sha1_byte_stream_hasher_core.
`timescale 1ns / 1ps
module sha1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during digest");
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[34:32] == 3'd4)))
    else $error("last flag mismatch");
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid &&
    out_tdata[34:32] == $past(out_tdata[34:32]) + 3'd1)
    else $error("word position skipped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
endmodule

bind sha1_byte_stream_hasher_core sha1_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
